// ----- rtl/tlbt_pkg.sv -----
// ----------------------------------------------------------------------------
// tlbt_pkg
// shared constants, state codes and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none

package tlbt_pkg;

    localparam int TLB_ENTRIES = 16;
    localparam int TLB_IDX_W   = $clog2(TLB_ENTRIES);
    localparam int AGE_W       = $clog2(TLB_ENTRIES);
    localparam int TLB_CNT_W   = $clog2(TLB_ENTRIES + 1);
    localparam int OFFSET_W    = 12;
    localparam int PAGE_W      = 20;
    localparam int FRAME_W     = 20;
    localparam int FCOUNT_W    = FRAME_W + 1;
    localparam int VA_W        = 32;
    localparam int TOTAL_W     = 32;
    localparam int CAP_W       = 5;
    localparam int PAGE_DEPTH  = 1 << PAGE_W;
    localparam int FRAME_DEPTH = 1 << FRAME_W;
    localparam logic [FCOUNT_W-1:0] FRAME_LIMIT = FCOUNT_W'(1) << FRAME_W;
    localparam logic [CAP_W-1:0]    CAP_RESET   = CAP_W'(TLB_ENTRIES);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_LOOKUP  = 5'b00010,
        ST_PT_READ = 5'b00100,
        ST_RESOLVE = 5'b01000,
        ST_OUTPUT  = 5'b10000
    } state_t;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic resolve;
    } dp_cmd_t;

    typedef struct packed {
        logic tlb_hit;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/tlbt_ram.sv -----
// ----------------------------------------------------------------------------
// tlbt_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module tlbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/tlbt_ctrl.sv -----
// ----------------------------------------------------------------------------
// tlbt_ctrl
// sequencer: tlb lookup, page table walk, resolve, result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module tlbt_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 addr_valid,
    output logic                      addr_stall,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output tlbt_pkg::dp_cmd_t         cmd,
    input  wire tlbt_pkg::dp_status_t status
);

    tlbt_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlbt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        unique case (state_reg)
            tlbt_pkg::ST_IDLE:
            begin
                if (addr_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = tlbt_pkg::ST_LOOKUP;
                end
            end
            tlbt_pkg::ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = status.tlb_hit ? tlbt_pkg::ST_OUTPUT : tlbt_pkg::ST_PT_READ;
            end
            tlbt_pkg::ST_PT_READ:
            begin
                state_next = tlbt_pkg::ST_RESOLVE;
            end
            tlbt_pkg::ST_RESOLVE:
            begin
                cmd.resolve = 1'b1;
                state_next  = tlbt_pkg::ST_OUTPUT;
            end
            tlbt_pkg::ST_OUTPUT:
            begin
                if (!result_stall)
                begin
                    state_next = tlbt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tlbt_pkg::ST_IDLE;
            end
        endcase
    end

    assign addr_stall   = (state_reg != tlbt_pkg::ST_IDLE);
    assign result_valid = (state_reg == tlbt_pkg::ST_OUTPUT);

endmodule

`default_nettype wire

// ----- rtl/tlbt_dp.sv -----
// ----------------------------------------------------------------------------
// tlbt_dp
// datapath: lru tlb, page table with reverse map, frame allocator, counters
// ----------------------------------------------------------------------------
`default_nettype none

module tlbt_dp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire tlbt_pkg::dp_cmd_t                  cmd,
    output tlbt_pkg::dp_status_t                    status,
    input  wire logic                               cfg_write_en,
    input  wire logic [tlbt_pkg::CAP_W-1:0]         cfg_write_data,
    input  wire logic [tlbt_pkg::VA_W-1:0]          virtual_address,
    output logic      [tlbt_pkg::VA_W-1:0]          physical_address,
    output logic      [tlbt_pkg::FRAME_W-1:0]       frame_number,
    output logic                                    tlb_hit,
    output logic                                    table_hit,
    output logic      [tlbt_pkg::FCOUNT_W-1:0]      frames_used,
    output logic      [tlbt_pkg::TOTAL_W-1:0]       tlb_hit_total,
    output logic      [tlbt_pkg::TOTAL_W-1:0]       table_hit_total
);

    localparam int N = tlbt_pkg::TLB_ENTRIES;

    logic [tlbt_pkg::CAP_W-1:0]    cap_reg;
    logic [tlbt_pkg::VA_W-1:0]     va_reg;
    logic [N-1:0]                  valid_reg, valid_next;
    logic [tlbt_pkg::AGE_W-1:0]    age_reg [N];
    logic [tlbt_pkg::AGE_W-1:0]    age_next [N];
    logic [tlbt_pkg::PAGE_W-1:0]   tpage_reg [N];
    logic [tlbt_pkg::FRAME_W-1:0]  tframe_reg [N];
    logic [tlbt_pkg::FCOUNT_W-1:0] nff_reg, nff_next;
    logic [tlbt_pkg::TOTAL_W-1:0]  thit_cnt_reg, phit_cnt_reg;

    logic [tlbt_pkg::PAGE_W-1:0]   page;
    logic [N-1:0]                  match;
    logic [tlbt_pkg::TLB_IDX_W-1:0] hit_idx;
    logic [tlbt_pkg::AGE_W-1:0]    hit_age;
    logic [tlbt_pkg::FRAME_W-1:0]  hit_frame;

    logic [tlbt_pkg::FRAME_W-1:0]  pf_rdata;
    logic [tlbt_pkg::PAGE_W-1:0]   fp_rdata;
    logic                          mapped;
    logic                          alloc;
    logic [tlbt_pkg::FRAME_W-1:0]  res_frame;

    logic [tlbt_pkg::TLB_CNT_W-1:0] used;
    logic [tlbt_pkg::TLB_CNT_W-1:0] cap_eff;
    logic                          full;
    logic                          do_fill;
    logic [tlbt_pkg::TLB_IDX_W-1:0] slot;
    logic                          slot_found;
    logic [tlbt_pkg::AGE_W-1:0]    oldest_age;

    assign page = va_reg[tlbt_pkg::OFFSET_W +: tlbt_pkg::PAGE_W];

    // associative compare, at most one entry matches
    always_comb
    begin
        hit_idx   = '0;
        hit_age   = '0;
        hit_frame = '0;
        for (int i = 0; i < N; i++)
        begin
            match[i] = valid_reg[i] && (tpage_reg[i] == page);
            if (match[i])
            begin
                hit_idx   = tlbt_pkg::TLB_IDX_W'(i);
                hit_age   = age_reg[i];
                hit_frame = tframe_reg[i];
            end
        end
    end

    assign status.tlb_hit = |match;

    // page table and reverse frame map; a page is mapped only when both agree
    tlbt_ram #(.WIDTH(tlbt_pkg::FRAME_W), .DEPTH(tlbt_pkg::PAGE_DEPTH)) u_page_frame (
        .clk   (clk),
        .we    (alloc),
        .waddr (page),
        .wdata (nff_reg[tlbt_pkg::FRAME_W-1:0]),
        .raddr (page),
        .rdata (pf_rdata)
    );

    tlbt_ram #(.WIDTH(tlbt_pkg::PAGE_W), .DEPTH(tlbt_pkg::FRAME_DEPTH)) u_frame_page (
        .clk   (clk),
        .we    (alloc),
        .waddr (nff_reg[tlbt_pkg::FRAME_W-1:0]),
        .wdata (page),
        .raddr (pf_rdata),
        .rdata (fp_rdata)
    );

    assign mapped    = ({1'b0, pf_rdata} < nff_reg) && (fp_rdata == page);
    assign alloc     = cmd.resolve && !mapped;
    assign res_frame = mapped ? pf_rdata : nff_reg[tlbt_pkg::FRAME_W-1:0];
    assign nff_next  = (alloc && (nff_reg < tlbt_pkg::FRAME_LIMIT)) ? nff_reg + 1'b1 : nff_reg;

    // fill slot selection
    always_comb
    begin
        used = '0;
        for (int i = 0; i < N; i++)
        begin
            used = used + tlbt_pkg::TLB_CNT_W'(valid_reg[i]);
        end
    end

    assign cap_eff    = (cap_reg > tlbt_pkg::CAP_W'(N)) ? tlbt_pkg::TLB_CNT_W'(N)
                                                         : tlbt_pkg::TLB_CNT_W'(cap_reg);
    assign full       = (used >= cap_eff);
    assign oldest_age = tlbt_pkg::AGE_W'(used - 1'b1);

    always_comb
    begin
        slot       = '0;
        slot_found = 1'b0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (full)
            begin
                // ages are distinct 0..used-1, so the oldest holds used-1
                if (valid_reg[i] && (age_reg[i] == oldest_age))
                begin
                    slot       = tlbt_pkg::TLB_IDX_W'(i);
                    slot_found = 1'b1;
                end
            end
            else if (!valid_reg[i])
            begin
                slot       = tlbt_pkg::TLB_IDX_W'(i);
                slot_found = 1'b1;
            end
        end
    end

    assign do_fill = cmd.resolve && slot_found && (used != '0 || !full);

    // lru age update
    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < N; i++)
        begin
            age_next[i] = age_reg[i];
        end
        if (cmd.lookup && status.tlb_hit)
        begin
            for (int i = 0; i < N; i++)
            begin
                if (valid_reg[i] && (age_reg[i] < hit_age))
                begin
                    age_next[i] = age_reg[i] + 1'b1;
                end
            end
            age_next[hit_idx] = '0;
        end
        else if (do_fill)
        begin
            for (int i = 0; i < N; i++)
            begin
                if (valid_reg[i])
                begin
                    age_next[i] = age_reg[i] + 1'b1;
                end
            end
            age_next[slot]   = '0;
            valid_next[slot] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg      <= tlbt_pkg::CAP_RESET;
            valid_reg    <= '0;
            nff_reg      <= '0;
            thit_cnt_reg <= '0;
            phit_cnt_reg <= '0;
            for (int i = 0; i < N; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_write_en)
            begin
                cap_reg <= cfg_write_data;
            end
            valid_reg <= valid_next;
            for (int i = 0; i < N; i++)
            begin
                age_reg[i] <= age_next[i];
            end
            nff_reg <= nff_next;
            if (cmd.lookup && status.tlb_hit)
            begin
                thit_cnt_reg <= thit_cnt_reg + 1'b1;
            end
            if (cmd.resolve && mapped)
            begin
                phit_cnt_reg <= phit_cnt_reg + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            va_reg <= virtual_address;
        end
        if (do_fill)
        begin
            tpage_reg[slot]  <= page;
            tframe_reg[slot] <= res_frame;
        end
        if (cmd.lookup && status.tlb_hit)
        begin
            frame_number <= hit_frame;
            tlb_hit      <= 1'b1;
            table_hit    <= 1'b0;
        end
        else if (cmd.resolve)
        begin
            frame_number <= res_frame;
            tlb_hit      <= 1'b0;
            table_hit    <= mapped;
        end
    end

    assign physical_address = {frame_number, va_reg[tlbt_pkg::OFFSET_W-1:0]};
    assign frames_used      = nff_reg;
    assign tlb_hit_total    = thit_cnt_reg;
    assign table_hit_total  = phit_cnt_reg;

endmodule

`default_nettype wire

// ----- rtl/tlb_lru_page_translator.sv -----
// ----------------------------------------------------------------------------
// tlb_lru_page_translator
// virtual to physical translation: lru tlb ahead of a demand-filled page table
// ----------------------------------------------------------------------------
// input channel: addr_valid / addr_stall carry one virtual_address per beat
// output channel: result_valid / result_stall carry one translation per beat
// a beat moves when valid is high and stall is low at a rising edge of clk
// config: cfg_write_en writes cfg_write_data into the tlb capacity register
// one address is in flight at a time; a tlb hit goes from lookup straight
// to output, while a miss passes through the page table read and resolve
// states, which wait on the two dependent page table ram reads (page to
// frame, then frame back to page to prove the mapping)
// the page table needs no clearing pass: a page counts as mapped only when
// its frame is below the allocation count and the reverse map points back
// reset (rst_n low, async) empties the tlb, the page table and the counters
// and sets the capacity to 16
// while the receiver stalls the result holds and no new address is taken
// ----------------------------------------------------------------------------
`default_nettype none

module tlb_lru_page_translator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write_en,
    input  wire logic [tlbt_pkg::CAP_W-1:0]    cfg_write_data,
    input  wire logic                          addr_valid,
    output logic                               addr_stall,
    input  wire logic [tlbt_pkg::VA_W-1:0]     virtual_address,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic      [tlbt_pkg::VA_W-1:0]     physical_address,
    output logic      [tlbt_pkg::FRAME_W-1:0]  frame_number,
    output logic                               tlb_hit,
    output logic                               table_hit,
    output logic      [tlbt_pkg::FCOUNT_W-1:0] frames_used,
    output logic      [tlbt_pkg::TOTAL_W-1:0]  tlb_hit_total,
    output logic      [tlbt_pkg::TOTAL_W-1:0]  table_hit_total
);

    // command and status between sequencer and datapath
    tlbt_pkg::dp_cmd_t    cmd;
    tlbt_pkg::dp_status_t status;

    tlbt_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .addr_valid   (addr_valid),
        .addr_stall   (addr_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .status       (status)
    );

    tlbt_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg_write_en     (cfg_write_en),
        .cfg_write_data   (cfg_write_data),
        .virtual_address  (virtual_address),
        .physical_address (physical_address),
        .frame_number     (frame_number),
        .tlb_hit          (tlb_hit),
        .table_hit        (table_hit),
        .frames_used      (frames_used),
        .tlb_hit_total    (tlb_hit_total),
        .table_hit_total  (table_hit_total)
    );

endmodule

`default_nettype wire
